/* src/ssd_pkg.sv */
package ssd_pkg;

	// Number of digit positions that the datapath is built for.
	localparam int MAX_DIGITS = 8;
	// Counter width for a position index or a digit count up to MAX_DIGITS.
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	// Driver register addresses.
	localparam logic [7:0] ADDR_NONE      = 8'h00;
	localparam logic [7:0] ADDR_DECODE    = 8'h09;
	localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
	localparam logic [7:0] ADDR_SCANLIM   = 8'h0B;
	localparam logic [7:0] ADDR_SHUTDOWN  = 8'h0C;

	localparam logic [7:0] SEG_BLANK   = 8'h00;
	localparam logic [7:0] SEG_MINUS   = 8'h01;
	localparam logic [7:0] SEG_POINT   = 8'h80;
	localparam logic [7:0] LEVEL_LIMIT = 8'd16;

	// Fixed-point reciprocal of ten: (x * RECIP10) >> 35 is x / 10 for any 32-bit x.
	localparam logic [31:0] RECIP10     = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_BRIGHT = 2'd1,
		CMD_RAW    = 2'd2,
		CMD_NUMBER = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BRIGHT = 2'd1,
		ST_DECODE = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic {
		REG_DIGIT_COUNT = 1'b0,
		REG_DECODE_ON   = 1'b1
	} reg_idx_t;

	// Microprogram fields.
	typedef enum logic [1:0] {
		A_CONST,
		A_RAW,
		A_POS
	} asel_t;

	typedef enum logic [2:0] {
		D_ZERO,
		D_ONE,
		D_DECODE,
		D_SCAN,
		D_LEVEL,
		D_SYM,
		D_SEG
	} dsel_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CHECK,
		OP_EXTRACT,
		OP_DIGIT
	} op_t;

	typedef enum logic [2:0] {
		BR_DISPATCH,
		BR_NEXT,
		BR_FAIL,
		BR_LOOP,
		BR_LOOP_END,
		BR_END
	} br_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		logic  emit;
		logic  wr;
		logic  last;
		asel_t asel;
		logic  [7:0] cval;
		dsel_t dsel;
		op_t   op;
		br_t   br;
		step_t target;
	} cw_t;

	// Control from the sequencer to the number datapath.
	typedef struct packed {
		logic load;
		logic extract;
		logic shift;
	} num_ctrl_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_INIT     = 4'd1;
	localparam step_t STEP_BRIGHT   = 4'd6;
	localparam step_t STEP_RAW      = 4'd10;
	localparam step_t STEP_NUM      = 4'd12;
	localparam step_t STEP_NUM_EXT  = 4'd13;
	localparam step_t STEP_NUM_EMIT = 4'd14;
	localparam step_t STEP_NOWRITE  = 4'd15;

	function automatic cw_t cw_write(asel_t a, logic [7:0] c, dsel_t d, logic l, br_t b);
		cw_t w;
		w        = '0;
		w.emit   = 1'b1;
		w.wr     = 1'b1;
		w.last   = l;
		w.asel   = a;
		w.cval   = c;
		w.dsel   = d;
		w.op     = OP_NONE;
		w.br     = b;
		w.target = STEP_IDLE;
		return w;
	endfunction

	function automatic cw_t cw_ctl(op_t o, br_t b, step_t t);
		cw_t w;
		w        = '0;
		w.asel   = A_CONST;
		w.cval   = ADDR_NONE;
		w.dsel   = D_ZERO;
		w.op     = o;
		w.br     = b;
		w.target = t;
		return w;
	endfunction

	// The microprogram.
	function automatic cw_t ucode(step_t s);
		cw_t w;
		unique case (s)
			STEP_IDLE:     w = cw_ctl(OP_NONE, BR_DISPATCH, STEP_IDLE);
			STEP_INIT:     w = cw_write(A_CONST, ADDR_SHUTDOWN, D_ZERO, 1'b0, BR_NEXT);
			4'd2:          w = cw_write(A_CONST, ADDR_DECODE, D_DECODE, 1'b0, BR_NEXT);
			4'd3:          w = cw_write(A_CONST, ADDR_SCANLIM, D_SCAN, 1'b0, BR_NEXT);
			4'd4:          w = cw_write(A_CONST, ADDR_INTENSITY, D_LEVEL, 1'b0, BR_NEXT);
			4'd5:          w = cw_write(A_CONST, ADDR_SHUTDOWN, D_ONE, 1'b1, BR_END);
			STEP_BRIGHT:   w = cw_ctl(OP_CHECK, BR_FAIL, STEP_NOWRITE);
			4'd7:          w = cw_write(A_CONST, ADDR_SHUTDOWN, D_ZERO, 1'b0, BR_NEXT);
			4'd8:          w = cw_write(A_CONST, ADDR_INTENSITY, D_LEVEL, 1'b0, BR_NEXT);
			4'd9:          w = cw_write(A_CONST, ADDR_SHUTDOWN, D_ONE, 1'b1, BR_END);
			STEP_RAW:      w = cw_ctl(OP_CHECK, BR_FAIL, STEP_NOWRITE);
			4'd11:         w = cw_write(A_RAW, ADDR_NONE, D_SYM, 1'b1, BR_END);
			STEP_NUM:      w = cw_ctl(OP_CHECK, BR_FAIL, STEP_NOWRITE);
			STEP_NUM_EXT:  w = cw_ctl(OP_EXTRACT, BR_LOOP, STEP_IDLE);
			STEP_NUM_EMIT: begin
				w    = cw_write(A_POS, ADDR_NONE, D_SEG, 1'b0, BR_LOOP_END);
				w.op = OP_DIGIT;
			end
			STEP_NOWRITE: begin
				w    = cw_write(A_CONST, ADDR_NONE, D_ZERO, 1'b1, BR_END);
				w.wr = 1'b0;
			end
			default:       w = cw_ctl(OP_NONE, BR_END, STEP_IDLE);
		endcase
		return w;
	endfunction

	function automatic step_t entry(cmd_t c);
		step_t s;
		unique case (c)
			CMD_INIT:   s = STEP_INIT;
			CMD_BRIGHT: s = STEP_BRIGHT;
			CMD_RAW:    s = STEP_RAW;
			CMD_NUMBER: s = STEP_NUM;
			default:    s = STEP_IDLE;
		endcase
		return s;
	endfunction

endpackage

/* src/seven_segment_display_command_writer.sv */
// Channel  Direction  Transaction content
// -------  ---------  ---------------------------------------------------------
// s_*      in         one command: tuser = cmd, tdata = value .. symbol_data
// m_*      out        one register write or status: tdata = addr/data,
//                     tuser = write_valid/status, tlast = final of the command
// cfg_*    in         register write: 0 digit_count, 1 decode_on
//
// The work per command is set by the microprogram: one step per register
// write, plus a check step for every command but initialize, and for a
// number one divide-by-ten step per digit in use. A command that ends in a
// status without a write has its check step and one status step.
// A command is taken only while the sequencer sits at its idle step; the next
// command is taken as soon as the final transaction has been loaded into the
// output register, even if that transaction is still waiting.
// A write step holds while the output register is full and not being taken.
// Reset clears the sequencer, the output valid and the two configuration
// registers (digit_count 8, decode_on 0); there is no memory to clear.
module seven_segment_display_command_writer import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] value, [35:32] frac_digits, [36] point_on, [44:37] level,
	// [52:45] digit_addr, [60:53] symbol_data, [63:61] zero
	input  logic [63:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] reg_addr, [15:8] reg_data
	output logic [15:0] m_tdata,
	// [0] write_valid, [2:1] status
	output logic [2:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	// Configuration.
	logic [3:0] digit_count_q;
	logic       decode_q;

	// Sequencer.
	step_t   pc_q;
	step_t   pc_next;
	cnt_t    cnt_q;
	status_t st_q;
	cw_t     cw;
	logic    accept;
	logic    adv;
	logic    done;
	logic    fail;
	status_t st_chk;

	// Latched command.
	cmd_t        cmd_q;
	logic [3:0]  frac_q;
	logic        point_q;
	logic [7:0]  level_q;
	logic [7:0]  daddr_q;
	logic [7:0]  sym_q;

	// Number datapath.
	num_ctrl_t  nctl;
	cnt_t       n_eff;
	cnt_t       keep;
	logic       oor;
	logic [7:0] seg;

	// Output register.
	logic        m_valid_q;
	logic [7:0]  m_addr_q;
	logic [7:0]  m_data_q;
	logic        m_wr_q;
	logic        m_last_q;
	status_t     m_st_q;
	logic [7:0]  addr_mux;
	logic [7:0]  data_mux;
	logic        last_mux;

	assign cw       = ucode(pc_q);
	assign s_tready = (pc_q == STEP_IDLE);
	assign accept   = s_tvalid && s_tready;

	// An emitting step may only fire when the output register can take it.
	assign adv  = !cw.emit || !m_valid_q || m_tready;
	assign done = (cnt_q == (n_eff - cnt_t'(1)));

	// A digit count of zero acts as one, any count beyond the build size as the maximum.
	always_comb begin
		if (digit_count_q == 4'd0) begin
			n_eff = cnt_t'(1);
		end else if (32'(digit_count_q) > MAX_DIGITS) begin
			n_eff = cnt_t'(MAX_DIGITS);
		end else begin
			n_eff = cnt_t'(digit_count_q);
		end
	end

	// Position that carries the point; zeros from here to the right are kept.
	assign keep = point_q ? (n_eff - cnt_t'(1) - cnt_t'(frac_q)) : (n_eff - cnt_t'(1));

	// Per-command checks, used by the check step of each branch.
	always_comb begin
		fail   = 1'b0;
		st_chk = ST_OK;
		unique case (cmd_q)
			CMD_BRIGHT: begin
				fail   = (level_q > LEVEL_LIMIT);
				st_chk = fail ? ST_BRIGHT : ST_OK;
			end
			CMD_RAW: begin
				fail   = decode_q;
				st_chk = decode_q ? ST_DECODE : ST_OK;
			end
			CMD_NUMBER: begin
				// Decode mode suppresses the digits but is not an error.
				if (oor || (point_q && (cnt_t'(frac_q) >= n_eff))) begin
					fail   = 1'b1;
					st_chk = ST_RANGE;
				end else begin
					fail   = decode_q;
					st_chk = ST_OK;
				end
			end
			default: begin
				fail   = 1'b0;
				st_chk = ST_OK;
			end
		endcase
	end

	// Next step.
	always_comb begin
		pc_next = pc_q;
		unique case (cw.br)
			BR_DISPATCH: if (accept) begin
				pc_next = entry(cmd_t'(s_tuser));
			end
			BR_NEXT: if (adv) begin
				pc_next = pc_q + step_t'(1);
			end
			BR_FAIL: begin
				pc_next = fail ? cw.target : (pc_q + step_t'(1));
			end
			BR_LOOP: if (done) begin
				pc_next = pc_q + step_t'(1);
			end
			BR_LOOP_END: if (adv && done) begin
				pc_next = STEP_IDLE;
			end
			BR_END: if (adv) begin
				pc_next = STEP_IDLE;
			end
			default: pc_next = STEP_IDLE;
		endcase
	end

	assign nctl.load    = accept;
	assign nctl.extract = (cw.op == OP_EXTRACT);
	assign nctl.shift   = (cw.op == OP_DIGIT) && adv;

	// Output field selection for the current step.
	always_comb begin
		case (cw.asel)
			A_CONST: addr_mux = cw.cval;
			A_RAW:   addr_mux = daddr_q;
			A_POS:   addr_mux = 8'(cnt_q) + 8'd1;
			default: addr_mux = ADDR_NONE;
		endcase
		case (cw.dsel)
			D_ZERO:   data_mux = 8'h00;
			D_ONE:    data_mux = 8'h01;
			D_DECODE: data_mux = decode_q ? 8'hFF : 8'h00;
			D_SCAN:   data_mux = 8'(n_eff - cnt_t'(1));
			D_LEVEL:  data_mux = level_q;
			D_SYM:    data_mux = sym_q;
			D_SEG:    data_mux = seg;
			default:  data_mux = 8'h00;
		endcase
		last_mux = cw.last || ((cw.br == BR_LOOP_END) && done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= 4'd8;
			decode_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIGIT_COUNT: digit_count_q <= cfg_data;
				REG_DECODE_ON:   decode_q      <= cfg_data[0];
				default:         decode_q      <= decode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= STEP_IDLE;
			cnt_q <= '0;
			st_q  <= ST_OK;
		end else begin
			pc_q <= pc_next;
			if (accept) begin
				cnt_q <= '0;
				st_q  <= ST_OK;
			end else begin
				if (cw.op == OP_CHECK) begin
					st_q <= st_chk;
				end
				if ((cw.op == OP_EXTRACT) || ((cw.op == OP_DIGIT) && adv)) begin
					cnt_q <= done ? '0 : (cnt_q + cnt_t'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(s_tuser);
			frac_q  <= s_tdata[35:32];
			point_q <= s_tdata[36];
			level_q <= s_tdata[44:37];
			daddr_q <= s_tdata[52:45];
			sym_q   <= s_tdata[60:53];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cw.emit && adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit && adv) begin
			m_addr_q <= addr_mux;
			m_data_q <= data_mux;
			m_wr_q   <= cw.wr;
			m_last_q <= last_mux;
			m_st_q   <= st_q;
		end
	end

	ssd_num_path u_num (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (nctl),
		.value  (s_tdata[31:0]),
		.n      (n_eff),
		.keep   (keep),
		.point  (point_q),
		.idx    (cnt_q),
		.oor    (oor),
		.seg    (seg)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_data_q, m_addr_q};
	assign m_tuser  = {m_st_q, m_wr_q};
	assign m_tlast  = m_last_q;

	// A transaction without a write always ends its command.
	a_nowrite_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_wr_q) |-> m_last_q)
		else $error("transaction without a write is not marked last");

	// While a non-final transaction waits, the command is still in progress.
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_last_q) |-> (pc_q != STEP_IDLE))
		else $error("sequencer idle before the final transaction was produced");

	// A stalled write step keeps its place and its position.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.emit && m_valid_q && !m_tready) |=> ($stable(pc_q) && $stable(cnt_q)))
		else $error("write step moved while the output was stalled");

	// Digit positions never run past the digits in use.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((pc_q == STEP_NUM_EXT) || (pc_q == STEP_NUM_EMIT)) |-> (cnt_q < n_eff))
		else $error("digit position beyond the digit count");

	// Each new command starts with a clean status.
	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == ST_OK))
		else $error("status not cleared at command start");

endmodule

/* src/ssd_num_path.sv */
// Number datapath: magnitude register, divide-by-ten digit extraction into a
// shift line, range check, and per-position segment pattern with blanking.
module ssd_num_path import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  num_ctrl_t   ctrl,
	input  logic [31:0] value,
	input  cnt_t        n,
	input  cnt_t        keep,
	input  logic        point,
	input  cnt_t        idx,
	output logic        oor,
	output logic [7:0]  seg
);

	logic [31:0] mag_q;
	logic        neg_q;
	logic        blank_q;
	logic [3:0]  digs_q [0:MAX_DIGITS];

	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] rem_full;
	logic [31:0] thr;
	logic        blank_now;
	logic        minus;

	function automatic logic [31:0] pow10(cnt_t k);
		logic [31:0] p;
		case (k)
			4'd0:    p = 32'd1;
			4'd1:    p = 32'd10;
			4'd2:    p = 32'd100;
			4'd3:    p = 32'd1000;
			4'd4:    p = 32'd10000;
			4'd5:    p = 32'd100000;
			4'd6:    p = 32'd1000000;
			4'd7:    p = 32'd10000000;
			4'd8:    p = 32'd100000000;
			default: p = 32'd1000000000;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] seg_of(logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'h7E;
			4'd1:    s = 8'h30;
			4'd2:    s = 8'h6D;
			4'd3:    s = 8'h79;
			4'd4:    s = 8'h33;
			4'd5:    s = 8'h5B;
			4'd6:    s = 8'h5F;
			4'd7:    s = 8'h70;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h7B;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	assign prod     = 64'(mag_q) * 64'(RECIP10);
	assign quo      = 32'(prod >> RECIP_SHIFT);
	assign rem_full = mag_q - (quo << 3) - (quo << 1);

	// A negative number may only use n-1 digits, one position is the sign.
	assign thr = neg_q ? pow10(n - cnt_t'(1)) : pow10(n);
	assign oor = (mag_q >= thr);

	assign blank_now = blank_q && (idx < keep) && (digs_q[0] == 4'd0);
	assign minus     = neg_q && (((idx + cnt_t'(1)) == keep) || (digs_q[1] != 4'd0));

	always_comb begin
		if (blank_now) begin
			seg = minus ? SEG_MINUS : SEG_BLANK;
		end else begin
			seg = seg_of(digs_q[0]);
		end
		if (point && (idx == keep)) begin
			seg = seg | SEG_POINT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= 1'b1;
		end else if (ctrl.load) begin
			blank_q <= 1'b1;
		end else if (ctrl.shift) begin
			blank_q <= blank_now;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			neg_q <= value[31];
			mag_q <= value[31] ? (32'd0 - value) : value;
		end else if (ctrl.extract) begin
			mag_q <= quo;
		end
		if (ctrl.extract) begin
			// Digits arrive rightmost first, so they are pushed in at the left end.
			digs_q[0] <= rem_full[3:0];
			for (int j = 0; j < MAX_DIGITS; j++) begin
				digs_q[j+1] <= digs_q[j];
			end
		end else if (ctrl.shift) begin
			for (int j = 0; j < MAX_DIGITS; j++) begin
				digs_q[j] <= digs_q[j+1];
			end
			digs_q[MAX_DIGITS] <= 4'd0;
		end
	end

endmodule
